FILE: src/wpe_pkg.sv
// wpe_pkg: shared constants, types and helpers of the pixel pulse encoder
// used by every module under src; depends on nothing else
`timescale 1ns / 1ps

package wpe_pkg;

  localparam int unsigned CHAN_W           = 8;
  localparam int unsigned PROD_W           = 2 * CHAN_W;
  localparam int unsigned BITS_PER_PIXEL   = 3 * CHAN_W;
  localparam int unsigned PULSES_PER_PIXEL = BITS_PER_PIXEL + 1;
  localparam int unsigned PULSE_CNT_W      = $clog2(PULSES_PER_PIXEL);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned HIGH_W     = 8;
  localparam int unsigned LOW_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef logic [BITS_PER_PIXEL-1:0] pixel_word_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS   = 3'd0,
    REG_ONE_HIGH     = 3'd1,
    REG_ONE_LOW      = 3'd2,
    REG_ZERO_HIGH    = 3'd3,
    REG_ZERO_LOW     = 3'd4,
    REG_LATCH_LOW    = 3'd5
  } cfg_reg_t;

  // bit timing set handed to the pulse generator
  typedef struct packed {
    logic [HIGH_W-1:0] one_high;
    logic [HIGH_W-1:0] one_low;
    logic [HIGH_W-1:0] zero_high;
    logic [HIGH_W-1:0] zero_low;
    logic [LOW_W-1:0]  latch_low;
  } timing_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

  // floor(x / 255) for any product of two 8-bit values
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {{(CHAN_W + 1){1'b0}}, x[PROD_W-1:CHAN_W]} + (PROD_W + 1)'(1);
    return t[PROD_W-1:CHAN_W];
  endfunction

endpackage

FILE: src/wpe_queue.sv
// wpe_queue: short queue of scaled pixel words between front and back
// depends on wpe_pkg
`timescale 1ns / 1ps

module wpe_queue
  import wpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pixel_word_t            push_data,
  input  logic                   pop,
  output pixel_word_t            rd_data,
  output logic                   empty,
  output logic [QUEUE_CNT_W-1:0] count
);

  pixel_word_t            entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;

  assign rd_data = entries[rd_ptr];
  assign empty   = (count == '0);

  // storage, written at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && (count == QUEUE_CNT_W'(QUEUE_DEPTH))))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue read while empty");

endmodule

FILE: src/wpe_front.sv
// wpe_front: accepts a pixel, scales each channel by brightness, builds the grb word
// depends on wpe_pkg; feeds wpe_queue
`timescale 1ns / 1ps

module wpe_front
  import wpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CHAN_W-1:0]      red,
  input  logic [CHAN_W-1:0]      green,
  input  logic [CHAN_W-1:0]      blue,
  input  logic [CHAN_W-1:0]      brightness,
  input  logic [QUEUE_CNT_W-1:0] queue_count,
  output logic                   busy,
  output logic                   push,
  output pixel_word_t            push_data
);

  logic                  s1_valid;
  logic [PROD_W-1:0]     prod_r;
  logic [PROD_W-1:0]     prod_g;
  logic [PROD_W-1:0]     prod_b;
  logic [QUEUE_CNT_W:0]  reserved;
  logic                  accept;

  // a pixel in the multiply stage already holds a queue slot
  assign reserved = {1'b0, queue_count} + (QUEUE_CNT_W + 1)'(s1_valid);
  assign busy     = (reserved >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
  assign accept   = start && !busy;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= PROD_W'(red)   * PROD_W'(brightness);
      prod_g <= PROD_W'(green) * PROD_W'(brightness);
      prod_b <= PROD_W'(blue)  * PROD_W'(brightness);
    end
  end

  // divide by 255 and pack green, red, blue into the queue
  assign push      = s1_valid;
  assign push_data = {div255(prod_g), div255(prod_r), div255(prod_b)};

endmodule

FILE: src/wpe_back.sv
// wpe_back: turns one queued pixel word into 24 bit pulses and a latch pulse
// depends on wpe_pkg; reads wpe_queue
`timescale 1ns / 1ps

module wpe_back
  import wpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  timing_t           timing,
  input  logic              queue_empty,
  input  pixel_word_t       queue_data,
  output logic              pop,
  output logic              pulse_valid,
  output logic [HIGH_W-1:0] high_time_us,
  output logic [LOW_W-1:0]  low_time_us,
  output logic              data_bit,
  output logic              is_latch,
  output logic              last
);

  back_state_t             state;
  back_state_t             state_next;
  pixel_word_t             word;
  logic [PULSE_CNT_W-1:0]  cnt;
  logic                    at_end;
  logic                    emit;
  logic [HIGH_W-1:0]       high_next;
  logic [LOW_W-1:0]        low_next;
  logic                    bit_next;

  assign at_end = (cnt == PULSE_CNT_W'(BITS_PER_PIXEL));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!queue_empty) state_next = BK_SEND;
      end
      BK_SEND: begin
        if (at_end && queue_empty) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    unique case (state)
      BK_IDLE: begin
        pop = !queue_empty;
      end
      BK_SEND: begin
        emit = 1'b1;
        pop  = at_end && !queue_empty;
      end
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  // pulse fields for the current bit, msb first
  always_comb begin
    if (at_end) begin
      bit_next  = 1'b0;
      high_next = '0;
      low_next  = timing.latch_low;
    end else if (word[BITS_PER_PIXEL-1]) begin
      bit_next  = 1'b1;
      high_next = timing.one_high;
      low_next  = LOW_W'(timing.one_low);
    end else begin
      bit_next  = 1'b0;
      high_next = timing.zero_high;
      low_next  = LOW_W'(timing.zero_low);
    end
  end

  // sequencer state, bit counter and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      cnt         <= '0;
      pulse_valid <= 1'b0;
    end else begin
      state       <= state_next;
      pulse_valid <= emit;
      if (pop) begin
        cnt <= '0;
      end else if (emit) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // shift word and output register
  always_ff @(posedge clk) begin
    if (pop) begin
      word <= queue_data;
    end else if (emit) begin
      word <= word << 1;
    end
    if (emit) begin
      high_time_us <= high_next;
      low_time_us  <= low_next;
      data_bit     <= bit_next;
      is_latch     <= at_end;
      last         <= at_end;
    end
  end

  a_bits_contiguous: assert property (@(posedge clk) disable iff (rst)
    pulse_valid && !is_latch |=> pulse_valid)
    else $error("gap inside a pixel's pulse run");

  a_run_starts_with_bit: assert property (@(posedge clk) disable iff (rst)
    $rose(pulse_valid) |-> !is_latch)
    else $error("pulse run opened with a latch symbol");

endmodule

FILE: src/ws2812_pixel_pulse_encoder_core.sv
// ws2812_pixel_pulse_encoder_core: top level, holds the timing/brightness registers
// start to first pulse strobe: multiply stage, queue, sequencer state, output register
// 25 pulses per pixel; the sequencer sends a queued pixel straight after the latch pulse
// a two-entry queue lets up to two more pixels be taken while a pixel is being sent
// reset: synchronous, clears queue and sequencer and loads the register defaults
// the receiver cannot stall: every pulse is on the ports for exactly one cycle
`timescale 1ns / 1ps

module ws2812_pixel_pulse_encoder_core
  import wpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CHAN_W-1:0]     red,
  input  logic [CHAN_W-1:0]     green,
  input  logic [CHAN_W-1:0]     blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  pulse_valid,
  output logic [HIGH_W-1:0]     high_time_us,
  output logic [LOW_W-1:0]      low_time_us,
  output logic                  data_bit,
  output logic                  is_latch,
  output logic                  last
);

  logic [CHAN_W-1:0]      brightness;
  timing_t                timing;
  logic                   push;
  pixel_word_t            push_data;
  logic                   pop;
  pixel_word_t            rd_data;
  logic                   queue_empty;
  logic [QUEUE_CNT_W-1:0] queue_count;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness       <= CHAN_W'(255);
      timing.one_high  <= HIGH_W'(1);
      timing.one_low   <= HIGH_W'(1);
      timing.zero_high <= HIGH_W'(1);
      timing.zero_low  <= HIGH_W'(2);
      timing.latch_low <= LOW_W'(50);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BRIGHTNESS: brightness       <= cfg_data[CHAN_W-1:0];
        REG_ONE_HIGH:   timing.one_high  <= cfg_data[HIGH_W-1:0];
        REG_ONE_LOW:    timing.one_low   <= cfg_data[HIGH_W-1:0];
        REG_ZERO_HIGH:  timing.zero_high <= cfg_data[HIGH_W-1:0];
        REG_ZERO_LOW:   timing.zero_low  <= cfg_data[HIGH_W-1:0];
        REG_LATCH_LOW:  timing.latch_low <= cfg_data[LOW_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel intake and scaling
  wpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .brightness  (brightness),
    .queue_count (queue_count),
    .busy        (busy),
    .push        (push),
    .push_data   (push_data)
  );

  // queue between intake and pulse generation
  wpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .empty     (queue_empty),
    .count     (queue_count)
  );

  // pulse sequencer
  wpe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .timing       (timing),
    .queue_empty  (queue_empty),
    .queue_data   (rd_data),
    .pop          (pop),
    .pulse_valid  (pulse_valid),
    .high_time_us (high_time_us),
    .low_time_us  (low_time_us),
    .data_bit     (data_bit),
    .is_latch     (is_latch),
    .last         (last)
  );

endmodule

FILE: sim/ws2812_pixel_pulse_encoder_core_tb.sv
// ws2812_pixel_pulse_encoder_core_tb: self-checking bench for the pixel pulse encoder
// predicts the 25 pulse descriptors of every pixel and checks them in order
// depends on src/wpe_pkg.sv and src/ws2812_pixel_pulse_encoder_core.sv
`timescale 1ns / 1ps

module ws2812_pixel_pulse_encoder_core_tb;
  import wpe_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned REPORT_LIMIT = 40;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned RAND_ITEMS   = 55;

  // indexes past the register list, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  // one line pulse descriptor
  typedef struct packed {
    logic [HIGH_W-1:0] high_us;
    logic [LOW_W-1:0]  low_us;
    logic              data_val;
    logic              latch;
    logic              fin;
  } pulse_t;

  // pulse predictor: own copy of the registers and the queue of pulses still due
  class pulse_predictor;
    logic [CHAN_W-1:0] brightness;
    logic [HIGH_W-1:0] one_high, one_low, zero_high, zero_low;
    logic [LOW_W-1:0]  latch_low;
    pulse_t            expected_pulses[$];
    int unsigned       errors;
    int unsigned       pixels;
    int unsigned       pulses;
    int unsigned       reg_writes;

    function new();
      brightness = 8'd255;
      one_high   = 8'd1;
      one_low    = 8'd1;
      zero_high  = 8'd1;
      zero_low   = 8'd2;
      latch_low  = 10'd50;
      errors     = 0;
      pixels     = 0;
      pulses     = 0;
      reg_writes = 0;
    endfunction

    // register write transfer, high bits beyond the register width are dropped
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_BRIGHTNESS: brightness = data[CHAN_W-1:0];
        REG_ONE_HIGH:   one_high   = data[HIGH_W-1:0];
        REG_ONE_LOW:    one_low    = data[HIGH_W-1:0];
        REG_ZERO_HIGH:  zero_high  = data[HIGH_W-1:0];
        REG_ZERO_LOW:   zero_low   = data[HIGH_W-1:0];
        REG_LATCH_LOW:  latch_low  = data[LOW_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(c * brightness / 255)
    function logic [CHAN_W-1:0] scale(logic [CHAN_W-1:0] c);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(c) * PROD_W'(brightness);
      return CHAN_W'(prod / PROD_W'(255));
    endfunction

    // accepted pixel: 24 data pulses in g, r, b order msb first, then the latch
    function void note_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      pixel_word_t word;
      pulse_t      p;
      word = {scale(g), scale(r), scale(b)};
      pixels++;
      for (int k = BITS_PER_PIXEL - 1; k >= 0; k--) begin
        if (word[k]) begin
          p = '{one_high, LOW_W'(one_low), 1'b1, 1'b0, 1'b0};
        end else begin
          p = '{zero_high, LOW_W'(zero_low), 1'b0, 1'b0, 1'b0};
        end
        expected_pulses.push_back(p);
      end
      p = '{'0, latch_low, 1'b0, 1'b1, 1'b1};
      expected_pulses.push_back(p);
    endfunction

    function void report(string field, logic [LOW_W-1:0] exp_v, logic [LOW_W-1:0] got_v);
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, field, exp_v, got_v);
      end
    endfunction

    // accepted pulse transfer against the oldest expected pulse
    function void check_pulse(pulse_t got);
      pulse_t exp_p;
      pulses++;
      if (expected_pulses.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t ns: unexpected pulse, expected none, got high %0d low %0d bit %0b",
                   $time, got.high_us, got.low_us, got.data_val);
        end
        return;
      end
      exp_p = expected_pulses.pop_front();
      if (got.high_us !== exp_p.high_us)
        report("high_time_us", LOW_W'(exp_p.high_us), LOW_W'(got.high_us));
      if (got.low_us !== exp_p.low_us)
        report("low_time_us", exp_p.low_us, got.low_us);
      if (got.data_val !== exp_p.data_val)
        report("data_bit", LOW_W'(exp_p.data_val), LOW_W'(got.data_val));
      if (got.latch !== exp_p.latch)
        report("is_latch", LOW_W'(exp_p.latch), LOW_W'(got.latch));
      if (got.fin !== exp_p.fin)
        report("last", LOW_W'(exp_p.fin), LOW_W'(got.fin));
    endfunction

    function int unsigned pending();
      return expected_pulses.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [CHAN_W-1:0]     red = '0;
  logic [CHAN_W-1:0]     green = '0;
  logic [CHAN_W-1:0]     blue = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pulse_valid;
  logic [HIGH_W-1:0]     high_time_us;
  logic [LOW_W-1:0]      low_time_us;
  logic                  data_bit;
  logic                  is_latch;
  logic                  last;

  pulse_predictor predictor = new();
  int unsigned    idle_cycles = 0;
  int unsigned    settings_run = 1;

  always #6 clk = ~clk;

  ws2812_pixel_pulse_encoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pulse_valid  (pulse_valid),
    .high_time_us (high_time_us),
    .low_time_us  (low_time_us),
    .data_bit     (data_bit),
    .is_latch     (is_latch),
    .last         (last)
  );

  // pulse monitor
  always @(posedge clk) begin
    if (!rst && pulse_valid) begin
      predictor.check_pulse('{high_time_us, low_time_us, data_bit, is_latch, last});
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || pulse_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("** ws2812_pixel_pulse_encoder_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // pixel transfer; start stays high, the caller lowers it
  task automatic push_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
    start <= 1'b1;
    red   <= r;
    green <= g;
    blue  <= b;
    do @(posedge clk); while (busy);
    predictor.note_pixel(r, g, b);
  endtask

  // register write transfer; valid stays high, the caller lowers it
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    predictor.write_reg(idx, data);
  endtask

  // full register set, junk in the unused upper data bits, optional spare indexes
  task automatic set_config(input logic [7:0] bright, input logic [7:0] oh,
                            input logic [7:0] ol, input logic [7:0] zh,
                            input logic [7:0] zl, input logic [9:0] ll, input bit spare);
    cfg_write(REG_BRIGHTNESS, {2'($urandom), bright});
    cfg_write(REG_ONE_HIGH, {2'($urandom), oh});
    cfg_write(REG_ONE_LOW, {2'($urandom), ol});
    cfg_write(REG_ZERO_HIGH, {2'($urandom), zh});
    cfg_write(REG_ZERO_LOW, {2'($urandom), zl});
    cfg_write(REG_LATCH_LOW, ll);
    if (spare) begin
      cfg_write(CFG_IDX_SPARE_LO, CFG_DATA_W'($urandom));
      cfg_write(CFG_IDX_SPARE_HI, CFG_DATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // wait until every expected pulse has been seen
  task automatic wait_drained();
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // random pixels sent in bursts with random gaps
  task automatic run_random(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        push_pixel(pick_byte(), pick_byte(), pick_byte());
        sent++;
      end
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(4, 26);
        default: gap = $urandom_range(20, 60);
      endcase
      if (sent >= count && gap == 0) gap = 1;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [9:0] ll;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults, back to back pixels
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'hAA, 8'h55, 8'hF0);
    push_pixel(8'h01, 8'h80, 8'hFE);
    push_pixel(8'h7F, 8'h00, 8'hFF);
    start <= 1'b0;
    wait_drained();

    // zero brightness sends all zero bits
    set_config(8'd0, 8'd9, 8'd3, 8'd4, 8'd11, 10'd100, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'h5A, 8'hC3, 8'h81);
    start <= 1'b0;
    wait_drained();

    // all timings at the top of their range
    set_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 10'd1023, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'h96, 8'h69, 8'h3C);
    start <= 1'b0;
    wait_drained();

    // zero timings pass through, minimum nonzero brightness
    set_config(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 10'd0, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd254, 8'd128, 8'd1);
    push_pixel(8'd0, 8'd0, 8'd0);
    start <= 1'b0;
    wait_drained();

    // mid and near-full brightness, one/zero timings that differ everywhere
    set_config(8'd128, 8'd200, 8'd17, 8'd33, 8'd250, 10'd512, 1'b0);
    push_pixel(8'd255, 8'd2, 8'd129);
    push_pixel(8'd1, 8'd254, 8'd128);
    start <= 1'b0;
    wait_drained();
    set_config(8'd254, 8'd1, 8'd2, 8'd3, 8'd4, 10'd777, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd128, 8'd64, 8'd32);
    start <= 1'b0;
    wait_drained();

    // random settings, random pixels
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       ll = 10'd0;
        1:       ll = 10'd1023;
        default: ll = 10'($urandom);
      endcase
      set_config(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(), ll,
                 $urandom_range(0, 2) == 0);
      run_random(RAND_ITEMS);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d pixels and %0d pulses under %0d register settings",
             predictor.pixels, predictor.pulses, settings_run);
    $display("%0d register write transfers, %0d errors",
             predictor.reg_writes, predictor.errors);
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("** ws2812_pixel_pulse_encoder_core: PASSED **");
    end else begin
      $display("** ws2812_pixel_pulse_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule
